// ===== rtl/core/ilist_pkg.sv =====
// Shared types and constants for the indexed list block.
// Holds list geometry, request and result encodings, and memory port structs.
// Depends on nothing; the top level, the sequencer and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package ilist_pkg;

  // List geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned WIDTH  = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Request and result field widths
  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 7;

  // Signed compare width for index checks
  localparam int unsigned CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = KIND_W + IDX_W + VAL_W;
  localparam int unsigned OUT_FIELDS_W = STAT_W + VAL_W + LEN_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic signed [WIDTH-1:0]  elem_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [IDX_W-1:0]  idx_t;
  typedef logic signed [CMP_W-1:0]  cmp_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_READ   = 3'd1,
    K_WRITE  = 3'd2,
    K_INSERT = 3'd3,
    K_DELETE = 3'd4,
    K_CLEAR  = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_PAST = 2'd1,
    ST_NEG  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SHIFT,
    S_RESP
  } state_e;

  // Input payload, first field in the lowest bits
  typedef struct packed {
    logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
    val_t                              value;
    idx_t                              index;
    logic [KIND_W-1:0]                 kind;
  } in_payload_t;

  // Output payload, first field in the lowest bits
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    logic [LEN_W-1:0]                    length;
    val_t                                read_value;
    status_e                             status;
  } out_payload_t;

  // Sequencer to element memory
  typedef struct packed {
    logic  we;
    addr_t waddr;
    elem_t wdata;
    addr_t raddr;
  } mem_req_t;

  // Sequencer status for the top level
  typedef struct packed {
    logic busy;
    cnt_t count;
  } ctrl_stat_t;

  // Store a request value in element width
  function automatic elem_t to_elem(val_t v);
    return elem_t'(v);
  endfunction

  // Sign-extend or trim an element to the result width
  function automatic val_t from_elem(elem_t e);
    return val_t'(e);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/indexed_list_insert_delete.sv =====
// Indexed list of signed elements with append, read, write, insert, delete
// and clear requests.
// Slave stream takes one request: tdata = kind[2:0], index[9:3], value[41:10].
// Master stream returns one result per request:
//   tdata = status[1:0], read_value[33:2], length[40:34].
// A negative index counts back from the end of the list.
// One request is worked at a time; s_axis_tready is high only while idle.
// Append, write, clear and failed checks go from the check state straight to the
// result; a read first waits for the registered RAM read; insert and delete
// first walk the entries from the position to the end of the list.
// Insert and delete move one element per cycle through the single-port-pair
// element RAM (read one entry, write it one slot over the next cycle).
// The result reaches the master side from S_RESP through the output register.
// A finished result waits in the output register while the receiver stalls;
// the next request is taken meanwhile, and its result waits until the
// register is freed.
// Reset clears the length and the handshake state; element storage is not
// cleared and needs no clearing pass.
// Depends on ilist_pkg, ilist_ram and ilist_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // kind [2:0], index [9:3], value [41:10], zero fill above
  input  wire logic [ilist_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status [1:0], read_value [33:2], length [40:34], zero fill above
  output logic      [ilist_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import ilist_pkg::*;

  mem_req_t   mem_req;
  elem_t      mem_rdata;
  ctrl_stat_t stat;

  // Element store
  ilist_ram #(
    .Width (WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Request sequencer
  ilist_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_o         (mem_req),
    .mem_rdata_i   (mem_rdata),
    .stat_o        (stat)
  );

`ifndef ASSERT_OFF
  // Length never exceeds the list depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= cnt_t'(DEPTH))
    else $error("list length above depth");

  // An accepted request starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> stat.busy)
    else $error("request accepted but sequencer idle");

  // The element store is written only while a request is worked
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> stat.busy)
    else $error("element write while idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ilist_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the element store of the indexed list; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ilist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write, then register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ilist_ctrl.sv =====
// Request sequencer of the indexed list: index checks, element shifting
// through the RAM, length register and the output register.
// Depends on ilist_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilist_ctrl (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ilist_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [ilist_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output ilist_pkg::mem_req_t                     mem_o,
  input  wire ilist_pkg::elem_t                   mem_rdata_i,
  output ilist_pkg::ctrl_stat_t                   stat_o
);

  import ilist_pkg::*;

  state_e       state_q, state_d;
  cnt_t         count_q, count_d;
  kind_e        kind_q, kind_d;
  idx_t         index_q, index_d;
  elem_t        value_q, value_d;
  addr_t        ptr_q, ptr_d;
  addr_t        wdst_q, wdst_d;
  addr_t        pos_q, pos_d;
  cnt_t         rem_q, rem_d;
  logic         pend_q, pend_d;
  status_e      res_status_q, res_status_d;
  val_t         res_data_q, res_data_d;
  logic         m_valid_q, m_valid_d;
  out_payload_t m_data_q, m_data_d;

  in_payload_t  in_req;
  cmp_t         idx_ext, cnt_ext, adj;
  status_e      chk;
  addr_t        pos;
  logic         full;
  logic         ins;

  assign in_req = in_payload_t'(s_axis_tdata);

  // Resolve the index against the current length
  always_comb begin
    idx_ext = cmp_t'(index_q);
    cnt_ext = cmp_t'(count_q);
    adj     = idx_ext + cnt_ext;
    chk     = ST_OK;
    pos     = idx_ext[ADDR_W-1:0];
    if (idx_ext >= cnt_ext) begin
      chk = ST_PAST;
    end else if (idx_ext < 0) begin
      pos = adj[ADDR_W-1:0];
      if (adj < 0) begin
        chk = ST_NEG;
      end
    end
  end

  assign full = (count_q == cnt_t'(DEPTH));
  assign ins  = (kind_q == K_INSERT);

  // Next state, memory accesses and result
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    kind_d       = kind_q;
    index_d      = index_q;
    value_d      = value_q;
    ptr_d        = ptr_q;
    wdst_d       = wdst_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    s_axis_tready = 1'b0;
    mem_o.we     = 1'b0;
    mem_o.waddr  = wdst_q;
    mem_o.wdata  = mem_rdata_i;
    mem_o.raddr  = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          kind_d  = kind_e'(in_req.kind);
          index_d = in_req.index;
          value_d = to_elem(in_req.value);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = ST_OK;
        res_data_d   = '0;
        state_d      = S_RESP;
        unique case (kind_q)
          K_APPEND: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              mem_o.we    = 1'b1;
              mem_o.waddr = count_q[ADDR_W-1:0];
              mem_o.wdata = value_q;
              count_d     = count_q + cnt_t'(1);
            end
          end
          K_READ: begin
            res_status_d = chk;
            if (chk == ST_OK) begin
              mem_o.raddr = pos;
              state_d     = S_RDWAIT;
            end
          end
          K_WRITE: begin
            res_status_d = chk;
            if (chk == ST_OK) begin
              mem_o.we    = 1'b1;
              mem_o.waddr = pos;
              mem_o.wdata = value_q;
            end
          end
          K_INSERT: begin
            res_status_d = chk;
            if (chk == ST_OK && full) begin
              res_status_d = ST_FULL;
            end else if (chk == ST_OK) begin
              // move entries pos..count-1 up, last one first
              pos_d   = pos;
              ptr_d   = count_q[ADDR_W-1:0] - addr_t'(1);
              rem_d   = count_q - cnt_t'(pos);
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          K_DELETE: begin
            res_status_d = chk;
            if (chk == ST_OK) begin
              // move entries pos+1..count-1 down, first one first
              pos_d   = pos;
              ptr_d   = pos + addr_t'(1);
              rem_d   = count_q - cnt_t'(pos) - cnt_t'(1);
              pend_d  = 1'b0;
              state_d = S_SHIFT;
            end
          end
          K_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_RDWAIT: begin
        res_data_d = from_elem(mem_rdata_i);
        state_d    = S_RESP;
      end

      S_SHIFT: begin
        // write back the entry read in the previous cycle
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = wdst_q;
          mem_o.wdata = mem_rdata_i;
        end
        if (rem_q != '0) begin
          mem_o.raddr = ptr_q;
          pend_d      = 1'b1;
          wdst_d      = ins ? ptr_q + addr_t'(1) : ptr_q - addr_t'(1);
          ptr_d       = ins ? ptr_q - addr_t'(1) : ptr_q + addr_t'(1);
          rem_d       = rem_q - cnt_t'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // drain done: place the new value or shrink the list
            if (ins) begin
              mem_o.we    = 1'b1;
              mem_o.waddr = pos_q;
              mem_o.wdata = value_q;
              count_d     = count_q + cnt_t'(1);
            end else begin
              count_d = count_q - cnt_t'(1);
            end
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d           = 1'b1;
          m_data_d.pad        = '0;
          m_data_d.length     = LEN_W'(count_q);
          m_data_d.read_value = res_data_q;
          m_data_d.status     = res_status_q;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    index_q      <= index_d;
    value_q      <= value_d;
    ptr_q        <= ptr_d;
    wdst_q       <= wdst_d;
    pos_q        <= pos_d;
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign stat_o.busy   = (state_q != S_IDLE);
  assign stat_o.count  = count_q;

endmodule

`default_nettype wire

// ===== sim/tb_indexed_list_insert_delete.sv =====
// Self-checking testbench for the indexed list block: a queued request driver that
// predicts each reply on a shadow list, a reply monitor and a stall watchdog.
// Depends on ilist_pkg and the indexed_list_insert_delete top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_indexed_list_insert_delete;
  import ilist_pkg::*;

  // Kinds outside the defined set; the block must ignore them
  localparam logic [KIND_W-1:0] K_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_TAIL    = 60;    // requests left when idling stops
  localparam int DRAIN_CYCLES = 80;    // longer than the slowest insert
  localparam int STALL_LIMIT  = 3000;  // cycles without any handshake
  localparam int PRINT_CAP    = 200;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  in_payload_t  request_queue[$];
  out_payload_t reply_queue[$];

  // Shadow copy of the list contents and length
  elem_t       list_mem [DEPTH];
  int unsigned list_len = 0;

  int mismatch_count = 0;
  int send_gap       = 0;
  int recv_gap       = 0;
  int stall_cycles   = 0;

  indexed_list_insert_delete dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Map a signed index onto a list position; negative counts from the end
  function automatic status_e locate(idx_t raw, output int pos);
    int idx;
    idx = int'(raw);
    pos = 0;
    if (idx >= int'(list_len)) return ST_PAST;
    if (idx < 0) begin
      idx += int'(list_len);
      if (idx < 0) return ST_NEG;
    end
    pos = idx;
    return ST_OK;
  endfunction

  // Apply one request to the shadow list and return the reply it should give
  function automatic out_payload_t apply_list_op(in_payload_t req);
    out_payload_t rsp;
    status_e      st;
    int           pos;
    int           i;
    rsp = '0;
    st  = ST_OK;
    pos = 0;
    case (req.kind)
      K_APPEND: begin
        if (list_len >= DEPTH) begin
          st = ST_FULL;
        end else begin
          list_mem[list_len] = elem_t'(req.value);
          list_len++;
        end
      end
      K_READ: begin
        st = locate(req.index, pos);
        if (st == ST_OK) rsp.read_value = val_t'(list_mem[pos]);
      end
      K_WRITE: begin
        st = locate(req.index, pos);
        if (st == ST_OK) list_mem[pos] = elem_t'(req.value);
      end
      K_INSERT: begin
        st = locate(req.index, pos);
        if (st == ST_OK) begin
          if (list_len >= DEPTH) begin
            st = ST_FULL;
          end else begin
            for (i = int'(list_len); i > pos; i--) list_mem[i] = list_mem[i-1];
            list_mem[pos] = elem_t'(req.value);
            list_len++;
          end
        end
      end
      K_DELETE: begin
        st = locate(req.index, pos);
        if (st == ST_OK) begin
          for (i = pos; i + 1 < int'(list_len); i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      K_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    rsp.status = st;
    rsp.length = LEN_W'(list_len);
    return rsp;
  endfunction

  task automatic push_req(logic [KIND_W-1:0] kind, idx_t index, val_t value);
    in_payload_t req;
    req       = '0;
    req.kind  = kind;
    req.index = index;
    req.value = value;
    request_queue.push_back(req);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Mostly short indexes, some near the extremes, some anywhere
  function automatic idx_t rand_index();
    int mag;
    case ($urandom_range(0, 3))
      0, 1: begin
        mag = $urandom_range(0, 12);
        return ($urandom_range(0, 1) == 1) ? idx_t'(-mag - 1) : idx_t'(mag);
      end
      2: begin
        return ($urandom_range(0, 1) == 1) ? idx_t'(-int'($urandom_range(52, 64)))
                                           : idx_t'($urandom_range(52, 63));
      end
      default: return idx_t'($urandom);
    endcase
  endfunction

  function automatic val_t rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  // Weighted toward growth so the list length wanders over its whole range
  function automatic logic [KIND_W-1:0] pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return K_APPEND;
    if (roll < 50) return K_READ;
    if (roll < 63) return K_WRITE;
    if (roll < 77) return K_INSERT;
    if (roll < 94) return K_DELETE;
    if (roll < 97) return K_CLEAR;
    return ($urandom_range(0, 1) == 1) ? K_SPARE7 : K_SPARE6;
  endfunction

  // Build the stimulus, release reset, then wait for the last reply
  initial begin : stimulus
    int made;
    int n;
    int j;
    int episode;

    // Empty list: every index check fails
    push_req(K_READ,   idx_t'(0),   32'h1);
    push_req(K_READ,   idx_t'(-1),  32'h2);
    push_req(K_DELETE, idx_t'(0),   32'h3);
    push_req(K_DELETE, idx_t'(-64), 32'h4);
    push_req(K_INSERT, idx_t'(0),   32'h5);
    push_req(K_WRITE,  idx_t'(-1),  32'h6);
    // Value extremes, reads at both ends, edits, spare kinds, a clear
    push_req(K_APPEND, idx_t'(63),  32'h7FFF_FFFF);
    push_req(K_APPEND, idx_t'(-64), 32'h8000_0000);
    push_req(K_APPEND, idx_t'(0),   32'h0000_0000);
    push_req(K_APPEND, idx_t'(-1),  32'hFFFF_FFFF);
    push_req(K_READ,   idx_t'(0),   32'h0);
    push_req(K_READ,   idx_t'(-1),  32'h0);
    push_req(K_READ,   idx_t'(-4),  32'h0);
    push_req(K_READ,   idx_t'(-5),  32'h0);
    push_req(K_READ,   idx_t'(4),   32'h0);
    push_req(K_WRITE,  idx_t'(1),   32'h5555_5555);
    push_req(K_WRITE,  idx_t'(-1),  32'hAAAA_AAAA);
    push_req(K_INSERT, idx_t'(0),   32'h1234_5678);
    push_req(K_INSERT, idx_t'(-1),  32'hCAFE_F00D);
    push_req(K_DELETE, idx_t'(0),   32'h0);
    push_req(K_DELETE, idx_t'(-1),  32'h0);
    push_req(K_READ,   idx_t'(63),  32'h0);
    push_req(K_READ,   idx_t'(-64), 32'h0);
    push_req(K_SPARE6, idx_t'(5),   32'hDEAD_BEEF);
    push_req(K_SPARE7, idx_t'(-3),  32'hBEEF_DEAD);
    push_req(K_CLEAR,  idx_t'(-64), 32'hFFFF_FFFF);

    // Random episodes: mostly mixed traffic, now and then a fill to full
    made    = 0;
    episode = 0;
    while (made < RANDOM_ITEMS) begin
      if (episode == 1 || $urandom_range(0, 15) == 0) begin
        n = $urandom_range(DEPTH, DEPTH + 2);
        push_req(K_CLEAR, rand_index(), rand_value());
        for (j = 0; j < n; j++) push_req(K_APPEND, rand_index(), rand_value());
        push_req(K_INSERT, idx_t'($urandom_range(0, DEPTH - 1)), rand_value());
        push_req(K_INSERT, idx_t'(-int'($urandom_range(1, DEPTH))), rand_value());
        push_req(K_READ, idx_t'(-64), rand_value());
        push_req(K_READ, idx_t'(63), rand_value());
        push_req(K_DELETE, rand_index(), rand_value());
        made += n + 6;
      end else begin
        n = $urandom_range(5, 20);
        for (j = 0; j < n; j++) push_req(pick_kind(), rand_index(), rand_value());
        made += n;
      end
      episode++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the request queue and the predicted replies to run dry
    do @(posedge clk_i);
    while (request_queue.size() != 0 || s_axis_tvalid || reply_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Request driver: hold a request until taken, idle in bursts after some
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        reply_queue.push_back(apply_list_op(in_payload_t'(s_axis_tdata)));
        if (request_queue.size() >= CALM_TAIL && $urandom_range(0, 4) == 0)
          send_gap = $urandom_range(1, 14);
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= request_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Reply monitor: compare each reply with the oldest prediction, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin : watch_replies
    out_payload_t got;
    out_payload_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_payload_t'(m_axis_tdata);
        if (reply_queue.size() == 0) begin
          report_mismatch("unexpected reply", 64'(m_axis_tdata), 64'h0);
        end else begin
          want = reply_queue.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", 64'(got.read_value), 64'(want.read_value));
          if (got.length !== want.length)
            report_mismatch("length", 64'(got.length), 64'(want.length));
          if (got.pad !== '0)
            report_mismatch("zero fill", 64'(got.pad), 64'h0);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (request_queue.size() >= CALM_TAIL && $urandom_range(0, 6) == 0)
          recv_gap = $urandom_range(1, 14);
      end
    end
  end

  // Watchdog: end the run when neither side has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
      stall_cycles++;
    else
      stall_cycles = 0;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
